FILE: design/sprc_pkg.sv
// Package: transaction types and codes for the shortest path relaxation core
`timescale 1ns / 1ps
package sprc_pkg;
   localparam int MaxVertices = 64;
   localparam int VertexBits  = $clog2(MaxVertices);
   localparam int WeightBits  = 16;
   localparam int DistBits    = 32;

   typedef enum logic [1:0] {
      MODE_WRITE = 2'd0,
      MODE_RUN   = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic {
      CSR_VERTEX_COUNT  = 1'b0,
      CSR_SOURCE_VERTEX = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]                   mode;
      logic [VertexBits-1:0]        from_vertex;
      logic [VertexBits-1:0]        to_vertex;
      logic signed [WeightBits-1:0] weight;
   } req_type;

   typedef struct packed {
      logic [VertexBits-1:0]      vertex;
      logic signed [DistBits-1:0] distance;
      logic                       reachable;
      logic                       negative_cycle;
      logic                       last;
   } rsp_type;

   // what a cell is told for one matrix entry (u,v)
   typedef struct packed {
      logic                       relax;     // apply candidate to v
      logic                       check;     // check pass, no update
      logic [VertexBits-1:0]      v;
      logic signed [DistBits-1:0] cand;
      logic                       cand_ok;
   } sprc_op_type;
endpackage

FILE: design/shortest_path_relaxation_core.sv
// Top level: edge matrix, run sequencer and row of distance cells
`timescale 1ns / 1ps
// Edge writes can follow back to back. Clear holds busy while it writes all
// MaxVertices*MaxVertices entries, one matrix entry per cycle, as does the
// clearing pass after reset. With n the vertex count clamped to 1..MaxVertices,
// a run holds busy for n-1 relaxation passes plus one check pass, each visiting
// every (u,v) entry through the RD, ADD and CMP states (edge memory read,
// distance read and saturating add, compare in the cell row). Without a negative
// cycle busy then stays high while the distances stream out one per cycle on
// rsp_valid, the last one in the first idle cycle; a negative cycle is reported
// by a single transaction in the first idle cycle. Results cannot be stalled.
module shortest_path_relaxation_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  sprc_pkg::req_type       req_data,
   output logic                    rsp_valid,
   output sprc_pkg::rsp_type       rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic                    csr_index,
   input  logic [31:0]             csr_data
);
   import sprc_pkg::*;

   localparam int VB = $clog2(MaxVertices);
   localparam int EB = 2 * VB;
   localparam int CB = VB + 1;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_RD, ST_ADD, ST_CMP, ST_EMIT
   } state_type;

   state_type state_ff;
   logic [6:0] vcount_ff;
   logic [5:0] source_ff;
   logic [VB-1:0] u_ff, v_ff;
   logic [EB-1:0] clr_ff;
   logic [CB-1:0] n_ff, pass_ff;
   logic changed_ff;

   // edge memory
   logic signed [WeightBits-1:0] wmem [MaxVertices*MaxVertices];
   logic                         pmem [MaxVertices*MaxVertices];
   logic signed [WeightBits-1:0] w_rd_ff;
   logic                         p_rd_ff;
   logic signed [DistBits-1:0] cand_ff;
   logic cand_ok_ff;

   logic accept;
   logic wr_en, wr_p;
   logic [EB-1:0] wr_a;
   logic [EB-1:0] rd_a;
   logic in_range;

   function automatic logic [CB-1:0] eff_n(input logic [6:0] c);
      logic [CB-1:0] r;
      if (c == 7'd0) begin
         r = CB'(1);
      end else if (32'(c) > MaxVertices) begin
         r = CB'(MaxVertices);
      end else begin
         r = CB'(c);
      end
      return r;
   endfunction

   assign accept    = start && !busy;
   assign busy      = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;
   assign in_range  = (32'(req_data.from_vertex) < MaxVertices) &&
                      (32'(req_data.to_vertex) < MaxVertices);

   always_comb begin
      wr_en = 1'b0;
      wr_p  = 1'b0;
      wr_a  = clr_ff;
      if (state_ff == ST_CLEAR) begin
         wr_en = 1'b1;
      end else if (accept && req_data.mode == MODE_WRITE && in_range) begin
         wr_en = 1'b1;
         wr_p  = 1'b1;
         wr_a  = {VB'(req_data.from_vertex), VB'(req_data.to_vertex)};
      end
   end

   assign rd_a = {u_ff, v_ff};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pmem[wr_a] <= wr_p;
         if (wr_p) begin
            wmem[wr_a] <= req_data.weight;
         end
      end
      p_rd_ff <= pmem[rd_a];
      w_rd_ff <= wmem[rd_a];
   end

   // cell row
   sprc_op_type op [MaxVertices+1];
   sprc_op_type op_head;
   logic signed [DistBits-1:0] rd [MaxVertices+1];
   logic rdk [MaxVertices+1];
   logic [MaxVertices-1:0] imp;
   logic init;
   logic [VB-1:0] rd_sel;

   assign rd[0]  = '0;
   assign rdk[0] = 1'b0;
   assign init   = accept && req_data.mode == MODE_RUN;
   assign rd_sel = (state_ff == ST_EMIT) ? v_ff : u_ff;

   always_comb begin
      op_head         = '0;
      op_head.relax   = state_ff == ST_CMP && pass_ff != n_ff;
      op_head.check   = state_ff == ST_CMP && pass_ff == n_ff;
      op_head.v       = VertexBits'(v_ff);
      op_head.cand    = cand_ff;
      op_head.cand_ok = cand_ok_ff;
   end

   assign op[0] = op_head;

   for (genvar i = 0; i < MaxVertices; i++) begin : g_cell
      sprc_cell #(.INDEX(i)) u_cell (
         .clock, .reset, .init,
         .init_known(32'(source_ff) == i && 32'(source_ff) < 32'(eff_n(vcount_ff))),
         .op_prev(op[i]), .op_next(op[i+1]),
         .rd_sel(VertexBits'(rd_sel)),
         .rd_prev(rd[i]), .rdk_prev(rdk[i]),
         .rd_next(rd[i+1]), .rdk_next(rdk[i+1]),
         .improve(imp[i])
      );
   end

   // saturating add of distance and weight
   logic signed [DistBits:0] sum;
   assign sum = {rd[MaxVertices][DistBits-1], rd[MaxVertices]}
                + (DistBits+1)'(w_rd_ff);

   logic last_u, last_v;
   assign last_v = 32'(v_ff) + 1 == 32'(n_ff);
   assign last_u = 32'(u_ff) + 1 == 32'(n_ff);

   always_ff @(posedge clock) begin
      rsp_valid <= 1'b0;
      if (state_ff == ST_ADD) begin
         cand_ok_ff <= p_rd_ff && rdk[MaxVertices];
         if (sum[DistBits] != sum[DistBits-1]) begin
            cand_ff <= sum[DistBits] ? {1'b1, {(DistBits-1){1'b0}}}
                                     : {1'b0, {(DistBits-1){1'b1}}};
         end else begin
            cand_ff <= sum[DistBits-1:0];
         end
      end
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         vcount_ff <= 7'd64;
         source_ff <= '0;
         u_ff      <= '0;
         v_ff      <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_VERTEX_COUNT) begin
               vcount_ff <= csr_data[6:0];
            end else begin
               source_ff <= csr_data[5:0];
            end
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (&clr_ff) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept && req_data.mode == MODE_CLEAR) begin
                  clr_ff   <= '0;
                  state_ff <= ST_CLEAR;
               end else if (init) begin
                  n_ff       <= eff_n(vcount_ff);
                  pass_ff    <= CB'(1);
                  changed_ff <= 1'b0;
                  u_ff       <= '0;
                  v_ff       <= '0;
                  state_ff   <= ST_RD;
               end
            end
            ST_RD:  state_ff <= ST_ADD;
            ST_ADD: state_ff <= ST_CMP;
            ST_CMP: begin
               if (|imp) begin
                  changed_ff <= 1'b1;
               end
               state_ff <= ST_RD;
               v_ff <= v_ff + 1'b1;
               if (last_v) begin
                  v_ff <= '0;
                  u_ff <= u_ff + 1'b1;
                  if (last_u) begin
                     u_ff <= '0;
                     if (pass_ff == n_ff) begin
                        if (changed_ff || (|imp)) begin
                           rsp_valid <= 1'b1;
                           rsp_data  <= '{vertex: '0, distance: '0, reachable: 1'b0,
                                          negative_cycle: 1'b1, last: 1'b1};
                           state_ff  <= ST_IDLE;
                        end else begin
                           state_ff <= ST_EMIT;
                        end
                     end else begin
                        pass_ff <= pass_ff + 1'b1;
                        changed_ff <= 1'b0;
                     end
                  end
               end
            end
            ST_EMIT: begin
               rsp_valid <= 1'b1;
               rsp_data  <= '{vertex: VertexBits'(v_ff),
                              distance: rdk[MaxVertices] ? rd[MaxVertices] : '0,
                              reachable: rdk[MaxVertices],
                              negative_cycle: 1'b0, last: last_v};
               v_ff <= v_ff + 1'b1;
               if (last_v) begin
                  v_ff     <= '0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // a read step keeps busy high, every emit step yields a transaction,
   // and the last transaction of a run leaves the block idle
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RD |=> busy) else $error("run ended early");
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |=> rsp_valid) else $error("emit lost");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> state_ff == ST_IDLE) else $error("last not final");
endmodule

FILE: design/sprc_cell.sv
// Cell: holds one vertex distance and forwards the relax operation to its neighbor
`timescale 1ns / 1ps
module sprc_cell #(
   parameter int INDEX = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          init,
   input  logic                          init_known,
   input  sprc_pkg::sprc_op_type         op_prev,
   output sprc_pkg::sprc_op_type         op_next,
   input  logic [sprc_pkg::VertexBits-1:0] rd_sel,
   input  logic signed [sprc_pkg::DistBits-1:0] rd_prev,
   input  logic                          rdk_prev,
   output logic signed [sprc_pkg::DistBits-1:0] rd_next,
   output logic                          rdk_next,
   output logic                          improve
);
   import sprc_pkg::*;

   logic signed [DistBits-1:0] dist_ff, dist_in;
   logic known_ff, known_in;
   logic hit;

   assign hit = op_prev.cand_ok && op_prev.v == VertexBits'(INDEX)
                && (!known_ff || dist_ff > op_prev.cand);
   assign improve = hit && (op_prev.relax || op_prev.check);

   always_comb begin
      dist_in  = dist_ff;
      known_in = known_ff;
      if (init) begin
         dist_in  = '0;
         known_in = init_known;
      end else if (hit && op_prev.relax) begin
         dist_in  = op_prev.cand;
         known_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff <= 1'b0;
      end else begin
         known_ff <= known_in;
      end
      dist_ff <= dist_in;
   end

   assign op_next  = op_prev;
   assign rd_next  = (rd_sel == VertexBits'(INDEX)) ? dist_ff : rd_prev;
   assign rdk_next = (rd_sel == VertexBits'(INDEX)) ? known_ff : rdk_prev;
endmodule

FILE: tb/sv/tb_top.sv
// Testbench: shortest path relaxation core, directed table plus random phases
`timescale 1ns / 1ps
module tb_top;
   import sprc_pkg::*;

   localparam int NumV = 64;

   typedef struct {
      logic          is_csr;
      csr_index_type idx;
      logic [31:0]   val;
      req_type       req;
      logic          has_exp;
      rsp_type       exp;
   } step_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [31:0] csr_data = '0;

   // shadow state of the block
   logic signed [15:0] edge_w [NumV*NumV];
   logic               edge_p [NumV*NumV];
   longint             dist_sh [NumV];
   logic               known [NumV];
   logic [6:0]         vcount;
   logic [5:0]         src;

   rsp_type expected_q[$];
   int      errors = 0;

   shortest_path_relaxation_core i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #50_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   always @(negedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            report("unexpected transaction, vertex", rsp_data.vertex, 0);
         end else begin
            want = expected_q.pop_front();
            if (rsp_data.vertex !== want.vertex)
               report("vertex", rsp_data.vertex, want.vertex);
            if (rsp_data.distance !== want.distance)
               report("distance", rsp_data.distance, want.distance);
            if (rsp_data.reachable !== want.reachable)
               report("reachable", rsp_data.reachable, want.reachable);
            if (rsp_data.negative_cycle !== want.negative_cycle)
               report("negative_cycle", rsp_data.negative_cycle, want.negative_cycle);
            if (rsp_data.last !== want.last)
               report("last", rsp_data.last, want.last);
         end
      end
   end

   function automatic longint sat_sum(input longint d, input longint w);
      longint s;
      s = d + w;
      if (s > 64'sd2147483647) return 64'sd2147483647;
      if (s < -64'sd2147483648) return -64'sd2147483648;
      return s;
   endfunction

   // one sweep over u then v; with apply clear, stops at the first improvement
   function automatic logic relax_sweep(input int n, input logic apply);
      logic   changed;
      longint cand;
      changed = 1'b0;
      for (int u = 0; u < n; u++) begin
         for (int v = 0; v < n; v++) begin
            if (edge_p[u*NumV+v] && known[u]) begin
               cand = sat_sum(dist_sh[u], longint'(edge_w[u*NumV+v]));
               if (!known[v] || dist_sh[v] > cand) begin
                  if (!apply) return 1'b1;
                  changed = 1'b1;
                  dist_sh[v] = cand;
                  known[v] = 1'b1;
               end
            end
         end
      end
      return changed;
   endfunction

   // updates the shadow state for one transaction and queues its results
   function automatic int predict_distances(input req_type r);
      int      n;
      rsp_type res;
      case (r.mode)
         MODE_WRITE: begin
            edge_w[r.from_vertex*NumV + r.to_vertex] = r.weight;
            edge_p[r.from_vertex*NumV + r.to_vertex] = 1'b1;
            return 0;
         end
         MODE_CLEAR: begin
            foreach (edge_p[i]) edge_p[i] = 1'b0;
            return 0;
         end
         MODE_RUN: begin
            n = (vcount == 0) ? 1 : (vcount > NumV) ? NumV : vcount;
            foreach (known[i]) known[i] = 1'b0;
            if (src < n) begin
               dist_sh[src] = 0;
               known[src] = 1'b1;
            end
            for (int i = 1; i < n; i++) void'(relax_sweep(n, 1'b1));
            if (relax_sweep(n, 1'b0)) begin
               res = '0;
               res.negative_cycle = 1'b1;
               res.last = 1'b1;
               expected_q.push_back(res);
               return 1;
            end
            for (int i = 0; i < n; i++) begin
               res.vertex = i[5:0];
               res.distance = known[i] ? dist_sh[i][31:0] : '0;
               res.reachable = known[i];
               res.negative_cycle = 1'b0;
               res.last = (i == n - 1);
               expected_q.push_back(res);
            end
            return n;
         end
         default: return 0;
      endcase
   endfunction

   // called at a rising edge; leaves start high
   task automatic send_item(input req_type r, output int produced);
      start <= 1'b1;
      req_data <= r;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      produced = predict_distances(r);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      if (idx == CSR_VERTEX_COUNT) vcount = val[6:0];
      else src = val[5:0];
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(negedge clock);
      while (expected_q.size() != 0 || busy) @(negedge clock);
      repeat (20) @(negedge clock);
      @(posedge clock);
   endtask

   function automatic req_type mk(input mode_type m, input int f, input int t, input int w);
      req_type r;
      r.mode = m;
      r.from_vertex = f[5:0];
      r.to_vertex = t[5:0];
      r.weight = w[15:0];
      return r;
   endfunction

   function automatic step_type row(input req_type r);
      step_type s;
      s.is_csr = 1'b0;
      s.idx = CSR_VERTEX_COUNT;
      s.val = '0;
      s.req = r;
      s.has_exp = 1'b0;
      s.exp = '0;
      return s;
   endfunction

   function automatic step_type csr_row(input csr_index_type idx, input logic [31:0] v);
      step_type s;
      s = row('0);
      s.is_csr = 1'b1;
      s.idx = idx;
      s.val = v;
      return s;
   endfunction

   function automatic step_type run_row(input logic chk, input rsp_type e);
      step_type s;
      s = row(mk(MODE_RUN, 0, 0, 0));
      s.has_exp = chk;
      s.exp = e;
      return s;
   endfunction

   function automatic rsp_type res_of(input int vx, input logic rch, input logic neg);
      rsp_type e;
      e = '0;
      e.vertex = vx[5:0];
      e.reachable = rch;
      e.negative_cycle = neg;
      e.last = 1'b1;
      return e;
   endfunction

   step_type steps[$];

   initial begin
      int      produced, n, burst;
      req_type r;
      foreach (edge_p[i]) edge_p[i] = 1'b0;
      foreach (known[i]) known[i] = 1'b0;
      vcount = 7'd64;
      src = '0;

      steps.push_back(csr_row(CSR_VERTEX_COUNT, 1));
      steps.push_back(run_row(1'b1, res_of(0, 1'b1, 1'b0)));
      steps.push_back(csr_row(CSR_VERTEX_COUNT, 0));        // zero counts as one vertex
      steps.push_back(run_row(1'b1, res_of(0, 1'b1, 1'b0)));
      steps.push_back(csr_row(CSR_SOURCE_VERTEX, 5));       // source outside the vertices in use
      steps.push_back(run_row(1'b1, res_of(0, 1'b0, 1'b0)));
      steps.push_back(csr_row(CSR_VERTEX_COUNT, 4));
      steps.push_back(csr_row(CSR_SOURCE_VERTEX, 0));
      steps.push_back(row(mk(MODE_WRITE, 0, 1, 32767)));
      steps.push_back(row(mk(MODE_WRITE, 1, 2, -32768)));
      steps.push_back(row(mk(MODE_WRITE, 2, 3, -1)));
      steps.push_back(row(mk(MODE_WRITE, 0, 63, 5)));       // unused vertex, kept but ignored
      steps.push_back(run_row(1'b0, '0));
      steps.push_back(row(mk(MODE_WRITE, 3, 1, -32768)));   // closes a negative cycle
      steps.push_back(run_row(1'b1, res_of(0, 1'b0, 1'b1)));
      steps.push_back(row(mk(MODE_NONE, 63, 63, -1)));
      steps.push_back(row(mk(MODE_CLEAR, 0, 0, 0)));
      steps.push_back(run_row(1'b0, '0));
      steps.push_back(csr_row(CSR_VERTEX_COUNT, 127));      // clamps to the full matrix
      steps.push_back(csr_row(CSR_SOURCE_VERTEX, 63));
      steps.push_back(row(mk(MODE_WRITE, 63, 0, 7)));
      steps.push_back(row(mk(MODE_WRITE, 0, 62, -9)));
      steps.push_back(run_row(1'b0, '0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (steps[i]) begin
         if (steps[i].is_csr) begin
            wait_idle();
            write_csr(steps[i].idx, steps[i].val);
         end else begin
            send_item(steps[i].req, produced);
            if (steps[i].has_exp && produced > 0)
               expected_q[expected_q.size() - produced] = steps[i].exp;
            start <= 1'b0;
            @(posedge clock);
         end
      end

      // random phases: new settings, an optional clear, a burst of edge writes and idle items, then a run
      repeat (30) begin
         wait_idle();
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) % 12 : $urandom_range(1, 8);
         write_csr(CSR_VERTEX_COUNT, {$urandom} & 32'hFFFF_FF80 | n);
         write_csr(CSR_SOURCE_VERTEX,
            ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, (n > 1) ? n - 1 : 0));
         if ($urandom_range(0, 5) == 0) begin
            send_item(mk(MODE_CLEAR, $urandom, $urandom, $urandom), produced);
         end
         repeat ($urandom_range(8, 16)) begin
            case ($urandom_range(0, 19))
               0: r = mk(MODE_NONE, $urandom, $urandom, $urandom);
               1, 2: r = mk(MODE_WRITE, $urandom, $urandom, $urandom);
               3: r = mk(MODE_WRITE, $urandom_range(0, 11), $urandom_range(0, 11),
                         $urandom_range(0, 40) - 30);
               default: r = mk(MODE_WRITE, $urandom_range(0, 11), $urandom_range(0, 11),
                         $urandom_range(0, 2000));
            endcase
            send_item(r, produced);
            if ($urandom_range(0, 3) == 0) begin
               burst = $urandom_range(1, 6);
               start <= 1'b0;
               repeat (burst) @(posedge clock);
            end
         end
         send_item(mk(MODE_RUN, $urandom, $urandom, $urandom), produced);
         start <= 1'b0;
         @(posedge clock);
      end

      wait_idle();
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
